// ===== rtl/core/pbfis_pkg.sv =====
// Shared types and constants for the per-binding free ID stack.
`timescale 1ns / 1ps
`default_nettype none
package pbfis_pkg;

  localparam int ID_W        = 10;
  localparam int BIND_W      = 5;
  localparam int COUNT_W     = 11;
  localparam int REG_SLOTS   = 4;
  localparam int REG_SLOT_W  = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = COUNT_W;

  localparam logic [CFG_IDX_W-1:0] CFG_BINDING_BASE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_BASE   = 3'd4;

  typedef enum logic [1:0] {
    REQ_POP     = 2'd0,
    REQ_PUSH    = 2'd1,
    REQ_REFILL  = 2'd2,
    REQ_RELEASE = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_EMPTY     = 2'd2,
    STATUS_FULL      = 2'd3
  } status_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } ctrl_state_e;

  typedef struct packed {
    logic [BIND_W-1:0]  binding;
    logic [COUNT_W-1:0] count;
  } slot_cfg_t;

endpackage
`default_nettype wire

// ===== rtl/core/pbfis_req_if.sv =====
// Request channel interface: valid/ready handshake with the request payload.
`timescale 1ns / 1ps
`default_nettype none
interface pbfis_req_if import pbfis_pkg::*; ();
  logic              valid;
  logic              ready;
  req_type_e         req_type;
  logic [BIND_W-1:0] binding_number;
  logic [ID_W-1:0]   push_id;

  modport source (output valid, output req_type, output binding_number, output push_id,
                  input ready);
  modport sink (input valid, input req_type, input binding_number, input push_id,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/core/pbfis_rsp_if.sv =====
// Response channel interface: valid/ready handshake with the response payload.
`timescale 1ns / 1ps
`default_nettype none
interface pbfis_rsp_if import pbfis_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [ID_W-1:0] popped_id;
  status_e         status;

  modport source (output valid, output popped_id, output status, input ready);
  modport sink (input valid, input popped_id, input status, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/pbfis_cfg_regs.sv =====
// Configuration register file holding the binding number and ID count of each slot.
`timescale 1ns / 1ps
`default_nettype none
module pbfis_cfg_regs import pbfis_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output slot_cfg_t                  slot_cfg_o [REG_SLOTS]
);

  slot_cfg_t slot_cfg_q [REG_SLOTS];
  logic [REG_SLOT_W-1:0] slot_sel;

  assign slot_sel = cfg_idx_i[REG_SLOT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < REG_SLOTS; s++) begin
        slot_cfg_q[s].binding <= BIND_W'(s);
        slot_cfg_q[s].count   <= '0;
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i < CFG_COUNT_BASE) begin
        slot_cfg_q[slot_sel].binding <= cfg_data_i[BIND_W-1:0];
      end else begin
        slot_cfg_q[slot_sel].count <= cfg_data_i[COUNT_W-1:0];
      end
    end
  end

  assign slot_cfg_o = slot_cfg_q;

endmodule
`default_nettype wire

// ===== rtl/core/pbfis_id_ram.sv =====
// Single-port-write, registered-read memory that holds the pushed IDs of all slots.
`timescale 1ns / 1ps
`default_nettype none
module pbfis_id_ram import pbfis_pkg::*; #(
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = 12
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [ID_W-1:0]   wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic [ID_W-1:0]        rdata_o
);

  logic [ID_W-1:0] mem [DEPTH];
  logic [ID_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== rtl/core/per_binding_free_id_stack.sv =====
// Per-binding free ID stacks: one LIFO of free IDs for each configured binding slot.
//
// A request transaction on req_i carries a request type, a binding number and
// an ID. Pop and push address the lowest present slot whose binding register
// matches; refill reloads every slot from its count register so that pops
// return 0, 1, 2 and so on; release empties all stacks and marks every slot
// absent. Each request produces exactly one response transaction on rsp_o.
// A refill takes effect at once: each slot keeps a low-water mark below which
// the stack still holds its refill contents, so only pushed IDs go to memory.
// A pop of a pushed ID reads the ID memory, whose read data is registered, and
// holds req_i.ready low until the read returns. The response sits in an
// output register, and the next request is taken while it is being consumed;
// if rsp_o stalls, req_i.ready drops until the response is taken. Reset
// clears all stacks, marks every slot absent and loads binding registers 0 to
// 3 and count registers 0. Configuration must be written only while no
// request is pending.
`timescale 1ns / 1ps
`default_nettype none
module per_binding_free_id_stack import pbfis_pkg::*; #(
  parameter int NUM_SLOTS = 4,
  parameter int MAX_IDS   = 1024
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  pbfis_req_if.sink                  req_i,
  pbfis_rsp_if.source                rsp_o
);

  localparam int IDX_W   = $clog2(MAX_IDS);
  localparam int LVL_W   = $clog2(MAX_IDS + 1);
  localparam int SLOT_IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int DEPTH   = NUM_SLOTS * (2 ** IDX_W);
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam logic [LVL_W-1:0] LVL_MAX = LVL_W'(MAX_IDS);
  localparam logic [LVL_W-1:0] LVL_ONE = LVL_W'(1);

  slot_cfg_t slot_cfg [REG_SLOTS];

  logic [LVL_W-1:0] level_q [NUM_SLOTS];
  logic [LVL_W-1:0] fill_q  [NUM_SLOTS];
  logic [LVL_W-1:0] low_q   [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] present_q;
  logic [LVL_W-1:0] clamp_n [NUM_SLOTS];

  ctrl_state_e state_q, state_d;
  logic req_fire;
  logic hit;
  logic [SLOT_IW-1:0] hit_slot;
  logic [LVL_W-1:0] sel_level, sel_fill, sel_low, pop_lvl;
  logic from_fill;
  logic [ID_W-1:0] fill_id;
  logic pop_ok, push_ok, need_read;
  logic [ID_W-1:0] popped_d, popped_q;
  status_e status_d, status_q;
  logic rsp_valid_q;
  logic mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [ID_W-1:0] mem_rdata;

  pbfis_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .slot_cfg_o (slot_cfg)
  );

  assign req_fire = req_i.valid && req_i.ready;

  always_comb begin
    for (int s = 0; s < NUM_SLOTS; s++) begin
      if (int'(slot_cfg[s].count) > MAX_IDS) begin
        clamp_n[s] = LVL_MAX;
      end else begin
        clamp_n[s] = LVL_W'(slot_cfg[s].count);
      end
    end
  end

  always_comb begin
    hit      = 1'b0;
    hit_slot = '0;
    for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
      if (present_q[s] && slot_cfg[s].binding == req_i.binding_number) begin
        hit      = 1'b1;
        hit_slot = SLOT_IW'(s);
      end
    end
  end

  assign sel_level = level_q[hit_slot];
  assign sel_fill  = fill_q[hit_slot];
  assign sel_low   = low_q[hit_slot];
  assign pop_lvl   = sel_level - LVL_ONE;
  assign from_fill = pop_lvl < sel_low;
  assign fill_id   = ID_W'(sel_fill - pop_lvl - LVL_ONE);

  always_comb begin
    popped_d  = '0;
    status_d  = STATUS_OK;
    pop_ok    = 1'b0;
    push_ok   = 1'b0;
    need_read = 1'b0;
    case (req_i.req_type)
      REQ_POP: begin
        if (!hit) begin
          status_d = STATUS_NOT_FOUND;
        end else if (sel_level == '0) begin
          status_d = STATUS_EMPTY;
        end else begin
          pop_ok = 1'b1;
          if (from_fill) begin
            popped_d = fill_id;
          end else begin
            need_read = 1'b1;
          end
        end
      end
      REQ_PUSH: begin
        if (!hit) begin
          status_d = STATUS_NOT_FOUND;
        end else if (sel_level >= LVL_MAX) begin
          status_d = STATUS_FULL;
        end else begin
          push_ok = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign mem_we    = req_fire && push_ok;
  assign mem_re    = req_fire && need_read;
  assign mem_waddr = ADDR_W'({hit_slot, sel_level[IDX_W-1:0]});
  assign mem_raddr = ADDR_W'({hit_slot, pop_lvl[IDX_W-1:0]});

  pbfis_id_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_id_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (req_i.push_id),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NUM_SLOTS; s++) begin
        level_q[s] <= '0;
        fill_q[s]  <= '0;
        low_q[s]   <= '0;
      end
      present_q <= '0;
    end else if (req_fire) begin
      for (int s = 0; s < NUM_SLOTS; s++) begin
        case (req_i.req_type)
          REQ_POP: begin
            if (pop_ok && hit_slot == SLOT_IW'(s)) begin
              level_q[s] <= pop_lvl;
              if (from_fill) begin
                low_q[s] <= pop_lvl;
              end
            end
          end
          REQ_PUSH: begin
            if (push_ok && hit_slot == SLOT_IW'(s)) begin
              level_q[s] <= sel_level + LVL_ONE;
            end
          end
          REQ_REFILL: begin
            level_q[s]   <= clamp_n[s];
            fill_q[s]    <= clamp_n[s];
            low_q[s]     <= clamp_n[s];
            present_q[s] <= clamp_n[s] != '0;
          end
          default: begin
            level_q[s]   <= '0;
            present_q[s] <= 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    case (state_q)
      ST_IDLE: state_d = (req_fire && need_read) ? ST_READ : ST_IDLE;
      ST_READ: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    case (state_q)
      ST_IDLE: req_i.ready = !rsp_valid_q || rsp_o.ready;
      default: req_i.ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if ((req_fire && !need_read) || state_q == ST_READ) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire && !need_read) begin
      popped_q <= popped_d;
      status_q <= status_d;
    end else if (state_q == ST_READ) begin
      popped_q <= mem_rdata;
      status_q <= STATUS_OK;
    end
  end

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.popped_id = popped_q;
  assign rsp_o.status    = status_q;

`ifndef NO_ASSERTIONS
  a_read_after_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_READ |-> $past(req_fire) && $past(req_i.req_type) == REQ_POP)
    else $error("Memory read state entered without an accepted pop.");

  a_no_accept_in_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_READ |-> !req_fire)
    else $error("Request accepted while a memory read is outstanding.");

  a_rsp_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> $past(req_fire) || $past(state_q == ST_READ))
    else $error("Response raised without a request behind it.");

  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_slot_chk
    a_absent_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
      !present_q[g] |-> level_q[g] == '0)
      else $error("Absent slot holds IDs.");

    a_low_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
      present_q[g] |-> low_q[g] <= level_q[g] && level_q[g] <= LVL_MAX)
      else $error("Slot low-water mark or level out of range.");
  end
`endif

endmodule
`default_nettype wire
